FILE: src/i2c_register_file_target_unit_macros.svh
// Assertion macros shared by the controller and the datapath.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef I2C_REGISTER_FILE_TARGET_UNIT_MACROS_SVH
`define I2C_REGISTER_FILE_TARGET_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define I2CRF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define I2CRF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define I2CRF_ASSERT_IMP(lbl, ante, cons, msg)
`define I2CRF_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: src/i2crf_pkg.sv
`timescale 1ns / 1ps
package i2crf_pkg;

	// Event codes carried in the kind field.
	localparam logic [3:0] KIND_ADDR_WRITE    = 4'd0;
	localparam logic [3:0] KIND_ADDR_READ     = 4'd1;
	localparam logic [3:0] KIND_BYTE_RECEIVED = 4'd2;
	localparam logic [3:0] KIND_BYTE_REQUEST  = 4'd3;
	localparam logic [3:0] KIND_STOP          = 4'd4;
	localparam logic [3:0] KIND_BUS_ERROR     = 4'd5;
	localparam logic [3:0] KIND_LOCAL_WRITE   = 4'd6;
	localparam logic [3:0] KIND_LOCAL_READ    = 4'd7;
	localparam logic [3:0] KIND_TAKE_FLAG     = 4'd8;

	// Message flag values and the read value for a register out of range.
	localparam logic [7:0] FLAG_T0       = 8'h80;
	localparam logic [7:0] FLAG_T1       = 8'h81;
	localparam logic [7:0] FLAG_T2       = 8'h82;
	localparam logic [7:0] OUT_OF_RANGE  = 8'h88;
	localparam logic [7:0] T1_DONE_INDEX = 8'd3;
	localparam logic [7:0] TARGET_0      = 8'd0;
	localparam logic [7:0] TARGET_1      = 8'd1;
	localparam logic [7:0] TARGET_2      = 8'd2;

	// Configuration register map, selected by paddr[2].
	localparam logic       REG_RX_SIZE  = 1'b0;
	localparam logic       REG_TX_SIZE  = 1'b1;
	localparam logic [4:0] SIZE_RST_VAL = 5'd16;

	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] data_byte;
		logic [7:0] local_reg;
	} req_t;

	typedef struct packed {
		logic [7:0] out_data;
		logic       end_transaction;
	} rsp_t;

	typedef struct packed {
		logic [4:0] rx_size;
		logic [4:0] tx_size;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_COMMIT
	} state_t;

endpackage

FILE: src/i2crf_ctrl.sv
`timescale 1ns / 1ps
`include "i2c_register_file_target_unit_macros.svh"
module i2crf_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  i2crf_pkg::dp_status_t  sts,
	output i2crf_pkg::ctrl_cmd_t   cmd
);
	import i2crf_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_stall  = 1'b1;
		cmd.accept = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_stall  = 1'b0;
				cmd.accept = req_valid;
			end
			ST_COMMIT: begin
				cmd.commit = sts.out_free;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	`I2CRF_ASSERT_NXT(a_accept_then_commit, cmd.accept, state_q == ST_COMMIT && req_stall,
		"accepted beat did not move to the commit state")
	`I2CRF_ASSERT_NXT(a_commit_then_idle, cmd.commit, state_q == ST_IDLE,
		"controller did not return to idle after commit")
	`I2CRF_ASSERT_NXT(a_hold_when_full, state_q == ST_COMMIT && !sts.out_free,
		state_q == ST_COMMIT, "result left the commit state while output was full")

endmodule

FILE: src/i2crf_dp.sv
`timescale 1ns / 1ps
`include "i2c_register_file_target_unit_macros.svh"
module i2crf_dp #(
	parameter int RX_REGS = 16,
	parameter int TX_REGS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  i2crf_pkg::req_t        req,
	input  i2crf_pkg::cfg_t        cfg,
	input  i2crf_pkg::ctrl_cmd_t   cmd,
	output i2crf_pkg::dp_status_t  sts,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output i2crf_pkg::rsp_t        rsp
);
	import i2crf_pkg::*;

	localparam int RX_AW = (RX_REGS > 1) ? $clog2(RX_REGS) : 1;
	localparam int TX_AW = (TX_REGS > 1) ? $clog2(TX_REGS) : 1;
	localparam logic [7:0] RX_DEPTH = 8'(RX_REGS);
	localparam logic [7:0] TX_DEPTH = 8'(TX_REGS);

	logic [7:0] rx_mem [RX_REGS];
	logic [7:0] tx_mem [TX_REGS];
	logic [RX_REGS-1:0] rx_vld_q;
	logic [TX_REGS-1:0] tx_vld_q;

	req_t       item_q;
	logic [7:0] rx_rd_q;
	logic [7:0] tx_rd_q;
	logic       rx_rd_vld_q;
	logic       tx_rd_vld_q;

	logic [7:0] rx_ptr_q, tx_ptr_q, target_q, flag_q, shared_q;
	logic       expect_q;
	rsp_t       rsp_q;
	logic       rsp_valid_q;

	logic [7:0] rx_bound, tx_bound;
	logic [7:0] rx_ptr_last, rx_rd_addr;
	logic [RX_AW-1:0] rx_rd_idx, rx_wr_idx;
	logic [TX_AW-1:0] tx_rd_idx, tx_wr_idx;
	logic [7:0] rx_rd_data, tx_rd_data;

	logic [7:0] rx_ptr_d, tx_ptr_d, target_d, flag_d, shared_d, last_byte, od_d;
	logic       expect_d, end_d, rx_we, tx_we;

	assign rx_bound    = ({3'b000, cfg.rx_size} < RX_DEPTH) ? {3'b000, cfg.rx_size} : RX_DEPTH;
	assign tx_bound    = ({3'b000, cfg.tx_size} < TX_DEPTH) ? {3'b000, cfg.tx_size} : TX_DEPTH;
	assign rx_ptr_last = rx_ptr_q - 8'd1;
	assign rx_rd_addr  = (req.kind == KIND_LOCAL_READ) ? req.local_reg : rx_ptr_last;
	assign rx_rd_idx   = rx_rd_addr[RX_AW-1:0];
	assign tx_rd_idx   = tx_ptr_q[TX_AW-1:0];
	assign rx_wr_idx   = rx_ptr_q[RX_AW-1:0];
	assign tx_wr_idx   = item_q.local_reg[TX_AW-1:0];
	assign rx_rd_data  = rx_rd_vld_q ? rx_rd_q : 8'h00;
	assign tx_rd_data  = tx_rd_vld_q ? tx_rd_q : 8'h00;

	// Capture the beat and read both files while the pointers are settled.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q      <= req;
			rx_rd_q     <= rx_mem[rx_rd_idx];
			tx_rd_q     <= tx_mem[tx_rd_idx];
			rx_rd_vld_q <= rx_vld_q[rx_rd_idx];
			tx_rd_vld_q <= tx_vld_q[tx_rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (rx_we) begin
			rx_mem[rx_wr_idx] <= item_q.data_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (tx_we) begin
			tx_mem[tx_wr_idx] <= item_q.data_byte;
		end
	end

	always_comb begin
		rx_ptr_d  = rx_ptr_q;
		tx_ptr_d  = tx_ptr_q;
		target_d  = target_q;
		flag_d    = flag_q;
		shared_d  = shared_q;
		expect_d  = expect_q;
		last_byte = 8'h00;
		od_d      = 8'h00;
		end_d     = 1'b0;
		rx_we     = 1'b0;
		tx_we     = 1'b0;
		unique case (item_q.kind) inside
			KIND_ADDR_WRITE: begin
				expect_d = 1'b1;
				od_d     = shared_q;
			end
			KIND_ADDR_READ: begin
				od_d = shared_q;
			end
			KIND_BYTE_RECEIVED: begin
				shared_d = item_q.data_byte;
				od_d     = item_q.data_byte;
				if (expect_q) begin
					rx_ptr_d = item_q.data_byte;
					tx_ptr_d = item_q.data_byte;
					target_d = item_q.data_byte;
					expect_d = 1'b0;
				end else begin
					if (rx_ptr_q < rx_bound) begin
						rx_we     = cmd.commit;
						rx_ptr_d  = rx_ptr_q + 8'd1;
						last_byte = item_q.data_byte;
					end else if (rx_ptr_q != 8'd0 && rx_ptr_last < rx_bound) begin
						last_byte = rx_rd_data;
					end
					if (target_q == TARGET_0) begin
						flag_d = FLAG_T0;
					end else if (target_q == TARGET_1 && rx_ptr_d == T1_DONE_INDEX) begin
						flag_d = FLAG_T1;
					end else if (target_q == TARGET_2 && last_byte[7]) begin
						flag_d = FLAG_T2;
					end
				end
			end
			KIND_BYTE_REQUEST: begin
				if (tx_ptr_q < tx_bound) begin
					shared_d = tx_rd_data;
					tx_ptr_d = tx_ptr_q + 8'd1;
					od_d     = tx_rd_data;
				end else begin
					od_d = shared_q;
				end
			end
			KIND_LOCAL_WRITE: begin
				tx_we = cmd.commit && (item_q.local_reg < tx_bound);
			end
			KIND_LOCAL_READ: begin
				od_d = (item_q.local_reg < rx_bound) ? rx_rd_data : OUT_OF_RANGE;
			end
			KIND_TAKE_FLAG: begin
				od_d   = flag_q;
				flag_d = 8'h00;
			end
			KIND_STOP, KIND_BUS_ERROR: begin
				end_d = 1'b1;
			end
			default: begin
				end_d = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_ptr_q <= 8'h00;
			tx_ptr_q <= 8'h00;
			target_q <= 8'h00;
			flag_q   <= 8'h00;
			shared_q <= 8'h00;
			expect_q <= 1'b0;
			rx_vld_q <= '0;
			tx_vld_q <= '0;
		end else if (cmd.commit) begin
			rx_ptr_q <= rx_ptr_d;
			tx_ptr_q <= tx_ptr_d;
			target_q <= target_d;
			flag_q   <= flag_d;
			shared_q <= shared_d;
			expect_q <= expect_d;
			if (rx_we) begin
				rx_vld_q[rx_wr_idx] <= 1'b1;
			end
			if (tx_we) begin
				tx_vld_q[tx_wr_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q.out_data        <= od_d;
			rsp_q.end_transaction <= end_d;
		end
	end

	assign sts.out_free = !rsp_valid_q || !rsp_stall;
	assign rsp_valid    = rsp_valid_q;
	assign rsp          = rsp_q;

	`I2CRF_ASSERT_NXT(a_commit_fills_output, cmd.commit, rsp_valid_q,
		"commit did not present a result")
	`I2CRF_ASSERT_NXT(a_addr_write_arms_index, cmd.commit && item_q.kind == KIND_ADDR_WRITE,
		expect_q, "address write did not arm the index byte")
	`I2CRF_ASSERT_NXT(a_take_clears_flag, cmd.commit && item_q.kind == KIND_TAKE_FLAG,
		flag_q == 8'h00, "taking the flag did not clear it")

endmodule

FILE: src/i2c_register_file_target_unit.sv
`timescale 1ns / 1ps
// Channel   Valid      Stall      Payload            Beat
// request   req_valid  req_stall  req (req_t)        one decoded bus or local event
// response  rsp_valid  rsp_stall  rsp (rsp_t)        one result per request beat
// config    psel/penable/pwrite   paddr, pwdata      one size register write
//
// Each request is accepted and then committed: the accept cycle reads the register files
// into registers synchronously, and the commit state, once the response register is
// free, commits the update and loads the response register.
// Reset clears all pointers, the flag and the valid bits of both register files at
// once, so unwritten entries read as zero; no clearing pass is needed.
// A full response register holds the commit back, but a new request is still taken
// while an earlier response waits.
module i2c_register_file_target_unit #(
	parameter int RX_REGS = 16,
	parameter int TX_REGS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  i2crf_pkg::req_t   req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output i2crf_pkg::rsp_t   rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import i2crf_pkg::*;

	cfg_t       cfg_q;
	ctrl_cmd_t  cmd;
	dp_status_t sts;
	logic       cfg_wr;

	// The bus port never inserts wait states. The two registers sit at byte
	// addresses 0 and 4, so bit 2 of the address selects between them.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rx_size <= SIZE_RST_VAL;
			cfg_q.tx_size <= SIZE_RST_VAL;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_RX_SIZE: cfg_q.rx_size <= pwdata[4:0];
				REG_TX_SIZE: cfg_q.tx_size <= pwdata[4:0];
				default: cfg_q.rx_size <= cfg_q.rx_size;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_RX_SIZE: prdata = {27'd0, cfg_q.rx_size};
			REG_TX_SIZE: prdata = {27'd0, cfg_q.tx_size};
			default:     prdata = 32'd0;
		endcase
	end

	// The controller sequences accept and commit; the datapath holds the
	// register files, the pointers, the message flag and the response register.
	i2crf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	i2crf_dp #(
		.RX_REGS (RX_REGS),
		.TX_REGS (TX_REGS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

FILE: tb/i2c_register_file_target_unit_tb.sv
`timescale 1ns / 1ps

module i2c_register_file_target_unit_tb;
	import i2crf_pkg::*;

	localparam int RX_DEPTH      = 16;
	localparam int TX_DEPTH      = 16;
	// Far above the slowest legal run: every beat waiting out both idle draws.
	localparam int CYCLE_LIMIT   = 400000;
	// Cycles waited after the last reply so that the block goes quiet.
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASE_COUNT   = 8;
	localparam int PHASE_BEATS   = 225;
	localparam int IDLE_MAX      = 13;

	// Tracks the register-file target's state and holds the replies it still owes.
	class target_scoreboard;
		logic [7:0] rx_file [RX_DEPTH];
		logic [7:0] tx_file [TX_DEPTH];
		logic [7:0] rx_ptr;
		logic [7:0] tx_ptr;
		logic [7:0] target_reg;
		logic [7:0] flag;
		logic [7:0] shared;
		logic       index_next;
		logic [4:0] rx_size;
		logic [4:0] tx_size;
		rsp_t       replies_due[$];
		int         errors;

		function new();
			foreach (rx_file[i]) rx_file[i] = 8'h00;
			foreach (tx_file[i]) tx_file[i] = 8'h00;
			rx_ptr = 8'h00;
			tx_ptr = 8'h00;
			target_reg = 8'h00;
			flag = 8'h00;
			shared = 8'h00;
			index_next = 1'b0;
			rx_size = SIZE_RST_VAL;
			tx_size = SIZE_RST_VAL;
			errors = 0;
		endfunction

		function int rx_bound();
			return (int'(rx_size) < RX_DEPTH) ? int'(rx_size) : RX_DEPTH;
		endfunction

		function int tx_bound();
			return (int'(tx_size) < TX_DEPTH) ? int'(tx_size) : TX_DEPTH;
		endfunction

		function void set_size(logic sel, logic [4:0] value);
			if (sel == REG_RX_SIZE) begin
				rx_size = value;
			end else begin
				tx_size = value;
			end
		endfunction

		function void store_bus_byte(logic [7:0] b);
			int         last;
			logic [7:0] last_byte;
			shared = b;
			if (index_next) begin
				rx_ptr = b;
				tx_ptr = b;
				target_reg = b;
				index_next = 1'b0;
				return;
			end
			if (int'(rx_ptr) < rx_bound()) begin
				rx_file[rx_ptr] = b;
				rx_ptr = rx_ptr + 8'd1;
			end
			// A last byte that lies outside the receive bound counts as zero.
			last = int'(rx_ptr) - 1;
			last_byte = 8'h00;
			if (last >= 0 && last < rx_bound())
				last_byte = rx_file[last];
			if (target_reg == TARGET_0)
				flag = FLAG_T0;
			else if (target_reg == TARGET_1 && rx_ptr == T1_DONE_INDEX)
				flag = FLAG_T1;
			else if (target_reg == TARGET_2 && last_byte[7])
				flag = FLAG_T2;
		endfunction

		// Called for every accepted request beat; queues the reply it must produce.
		function void note_event(req_t beat);
			rsp_t reply;
			reply = '0;
			case (beat.kind)
			KIND_ADDR_WRITE: begin
				index_next = 1'b1;
				reply.out_data = shared;
			end
			KIND_ADDR_READ: reply.out_data = shared;
			KIND_BYTE_RECEIVED: begin
				store_bus_byte(beat.data_byte);
				reply.out_data = shared;
			end
			KIND_BYTE_REQUEST: begin
				if (int'(tx_ptr) < tx_bound()) begin
					shared = tx_file[tx_ptr];
					tx_ptr = tx_ptr + 8'd1;
				end
				reply.out_data = shared;
			end
			KIND_LOCAL_WRITE: begin
				if (int'(beat.local_reg) < tx_bound())
					tx_file[beat.local_reg] = beat.data_byte;
			end
			KIND_LOCAL_READ: begin
				reply.out_data = (int'(beat.local_reg) < rx_bound()) ?
					rx_file[beat.local_reg] : OUT_OF_RANGE;
			end
			KIND_TAKE_FLAG: begin
				reply.out_data = flag;
				flag = 8'h00;
			end
			default: reply.end_transaction = 1'b1;
			endcase
			replies_due.push_back(reply);
		endfunction

		function void check_reply(rsp_t got);
			rsp_t want;
			if (replies_due.size() == 0) begin
				$error("unexpected reply: out_data %02h end_transaction %0b",
					got.out_data, got.end_transaction);
				errors++;
				return;
			end
			want = replies_due.pop_front();
			if (got.out_data !== want.out_data) begin
				$error("out_data: expected %02h, got %02h", want.out_data, got.out_data);
				errors++;
			end
			if (got.end_transaction !== want.end_transaction) begin
				$error("end_transaction: expected %0b, got %0b",
					want.end_transaction, got.end_transaction);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Upper bounds of the idle draws; a phase sets them to zero for back-to-back traffic.
	int req_idle_max = IDLE_MAX;
	int rsp_idle_max = IDLE_MAX;
	int sent_total = 0;
	int cycle_count = 0;

	target_scoreboard book = new();

	i2c_register_file_target_unit #(
		.RX_REGS(RX_DEPTH),
		.TX_REGS(TX_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The watchdog catches a hang anywhere: a lost beat, a stuck stall, a dead APB port.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic [7:0] rand_byte();
		logic [31:0] r;
		r = $urandom;
		return r[7:0];
	endfunction

	// Register numbers and index bytes mostly land near the files, so that the
	// bounds and the three flag targets are hit often; now and then any value.
	function automatic logic [7:0] near_reg();
		logic [31:0] r;
		r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 18);
		return r[7:0];
	endfunction

	// Sends one request beat after a random idle gap and records it once it is taken.
	// The payload is only changed in the cycle after the previous beat was accepted.
	task automatic send_event(input logic [3:0] k, input logic [7:0] d, input logic [7:0] r);
		int   gap;
		req_t beat;
		gap = (req_idle_max == 0) ? 0 : $urandom_range(0, req_idle_max);
		beat.kind = k;
		beat.data_byte = d;
		beat.local_reg = r;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= beat;
		do @(posedge clk); while (req_stall);
		book.note_event(beat);
		sent_total++;
	endtask

	// Drops the request valid and waits until every owed reply has come back.
	task automatic settle();
		req_valid <= 1'b0;
		while (book.replies_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes one size register over APB, then reads it back. The bus is then left idle
	// so that a following transfer starts on a fresh edge.
	task automatic program_size(input logic sel, input logic [4:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= {27'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		book.set_size(sel, value);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[4:0] !== value) begin
			$error("%s: expected %0d, got %0d",
				(sel == REG_RX_SIZE) ? "rx_size" : "tx_size", value, prdata[4:0]);
			book.errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly well-formed bus transactions with random content, plus local software
	// traffic, broken transactions and pure noise.
	task automatic random_traffic(input int quota);
		int         stop_at;
		int         pick;
		int         n;
		logic [3:0] k;
		logic [31:0] r;
		stop_at = sent_total + quota;
		while (sent_total < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				// A bus write: address, index byte, a run of data bytes that may run
				// past the receive size, and usually a stop or an error at the end.
				send_event(KIND_ADDR_WRITE, rand_byte(), rand_byte());
				send_event(KIND_BYTE_RECEIVED, near_reg(), rand_byte());
				n = $urandom_range(0, 20);
				repeat (n) send_event(KIND_BYTE_RECEIVED, rand_byte(), rand_byte());
				pick = $urandom_range(0, 9);
				if (pick < 7)
					send_event(KIND_STOP, rand_byte(), rand_byte());
				else if (pick < 9)
					send_event(KIND_BUS_ERROR, rand_byte(), rand_byte());
				if ($urandom_range(0, 1) == 1)
					send_event(KIND_TAKE_FLAG, rand_byte(), rand_byte());
			end else if (pick < 60) begin
				// A bus read, often preceded by a short write that only sets the pointer.
				if ($urandom_range(0, 1) == 1) begin
					send_event(KIND_ADDR_WRITE, rand_byte(), rand_byte());
					send_event(KIND_BYTE_RECEIVED, near_reg(), rand_byte());
					send_event(KIND_STOP, rand_byte(), rand_byte());
				end
				send_event(KIND_ADDR_READ, rand_byte(), rand_byte());
				n = $urandom_range(0, 20);
				repeat (n) send_event(KIND_BYTE_REQUEST, rand_byte(), rand_byte());
				send_event(KIND_STOP, rand_byte(), rand_byte());
			end else if (pick < 75) begin
				n = $urandom_range(1, 6);
				repeat (n) send_event(KIND_LOCAL_WRITE, rand_byte(), near_reg());
			end else if (pick < 88) begin
				n = $urandom_range(1, 6);
				repeat (n) send_event(KIND_LOCAL_READ, rand_byte(), near_reg());
				send_event(KIND_TAKE_FLAG, rand_byte(), rand_byte());
			end else begin
				// Noise: any kind code, unused ones included, in any order.
				n = $urandom_range(1, 4);
				repeat (n) begin
					r = $urandom_range(0, 15);
					k = r[3:0];
					send_event(k, rand_byte(), rand_byte());
				end
			end
		end
	endtask

	// The reply side draws its own stall length for every beat it takes.
	initial begin : reply_sink
		int hold;
		wait (arst_n === 1'b1);
		forever begin
			hold = (rsp_idle_max == 0) ? 0 : $urandom_range(0, rsp_idle_max);
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
			book.check_reply(rsp);
		end
	end

	initial begin : stimulus
		int          p;
		logic [31:0] r;
		logic [4:0]  rx_pick;
		logic [4:0]  tx_pick;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, run on the reset sizes of sixteen. The flag starts clear
		// and the receive file reads as zero before anything was written.
		send_event(KIND_TAKE_FLAG, 8'h00, 8'h00);
		send_event(KIND_LOCAL_WRITE, 8'hFF, 8'd0);
		send_event(KIND_LOCAL_WRITE, 8'h80, 8'd15);
		// A local write just past the transmit file is ignored.
		send_event(KIND_LOCAL_WRITE, 8'h55, 8'd16);
		// A local read out of range returns the fixed out-of-range byte.
		send_event(KIND_LOCAL_READ, 8'h00, 8'hFF);
		send_event(KIND_LOCAL_READ, 8'hFF, 8'd0);
		// Index byte 15 points at the last receive register and also selects target 15, the
		// next byte fills it, and the one after runs past the end; no flag is set.
		send_event(KIND_ADDR_WRITE, 8'h00, 8'h00);
		send_event(KIND_BYTE_RECEIVED, 8'd15, 8'h00);
		send_event(KIND_BYTE_RECEIVED, 8'hFF, 8'h00);
		send_event(KIND_BYTE_RECEIVED, 8'h01, 8'h00);
		send_event(KIND_TAKE_FLAG, 8'h00, 8'h00);
		// A read from transmit register 15, then one past the end that repeats it.
		send_event(KIND_ADDR_READ, 8'h00, 8'h00);
		send_event(KIND_BYTE_REQUEST, 8'h00, 8'h00);
		send_event(KIND_BYTE_REQUEST, 8'h00, 8'h00);
		send_event(KIND_STOP, 8'h00, 8'h00);
		// Target 1 raises its flag once the pointer reaches three.
		send_event(KIND_ADDR_WRITE, 8'h00, 8'h00);
		send_event(KIND_BYTE_RECEIVED, 8'd1, 8'h00);
		send_event(KIND_BYTE_RECEIVED, 8'h12, 8'h00);
		send_event(KIND_BYTE_RECEIVED, 8'h34, 8'h00);
		// Target 2 raises its flag when the last stored byte has its top bit set.
		send_event(KIND_ADDR_WRITE, 8'h00, 8'h00);
		send_event(KIND_BYTE_RECEIVED, 8'd2, 8'h00);
		send_event(KIND_BYTE_RECEIVED, 8'h80, 8'h00);
		send_event(KIND_TAKE_FLAG, 8'h00, 8'h00);
		send_event(KIND_BUS_ERROR, 8'h00, 8'h00);
		// An unused kind code ends the transaction like a bus error.
		send_event(4'hF, 8'hFF, 8'hFF);

		// Random phases. The first four use the extreme sizes, zero receive
		// registers among them; the rest draw sizes at random. Some phases run
		// with no idling on one or both sides.
		for (p = 0; p < PHASE_COUNT; p++) begin
			settle();
			case (p)
			0: begin
				rx_pick = 5'd16;
				tx_pick = 5'd16;
			end
			1: begin
				rx_pick = 5'd0;
				tx_pick = 5'd1;
			end
			2: begin
				rx_pick = 5'd16;
				tx_pick = 5'd1;
			end
			3: begin
				rx_pick = 5'd1;
				tx_pick = 5'd16;
			end
			default: begin
				r = $urandom_range(0, 16);
				rx_pick = r[4:0];
				r = $urandom_range(1, 16);
				tx_pick = r[4:0];
			end
			endcase
			program_size(REG_RX_SIZE, rx_pick);
			program_size(REG_TX_SIZE, tx_pick);
			req_idle_max = (p % 4 == 1) ? 0 : IDLE_MAX;
			rsp_idle_max = (p % 4 == 1 || p % 4 == 3) ? 0 : IDLE_MAX;
			random_traffic(PHASE_BEATS);
		end

		// All beats are in; wait for the last replies, then give the verdict.
		settle();
		if (book.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
